[hw/rtl/saa_pkg.sv]
// Shared constants and types for the shelf atlas allocator.
package saa_pkg;

  localparam int PAGE_SIZE   = 2048;
  localparam int MAX_SHELVES = 1024;

  // coordinate width inside a page and size width (holds PAGE_SIZE itself)
  localparam int CW = $clog2(PAGE_SIZE);
  localparam int SW = CW + 1;

  localparam int SHELF_AW   = $clog2(MAX_SHELVES);
  localparam int SHELF_CNTW = SHELF_AW + 1;

  localparam int PIECE_MAX = PAGE_SIZE - 2;

  // port field widths
  localparam int REQ_W    = 2;
  localparam int IN_WW    = 16;
  localparam int IN_HW    = 12;
  localparam int STAT_W   = 2;
  localparam int PAGE_W   = 8;
  localparam int OUT_CW   = 11;

  // bordered height and its upper tolerance
  localparam int AH_W  = IN_HW + 1;
  localparam int AHL_W = AH_W + 1;

  localparam logic [REQ_W-1:0] REQ_PLACE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FORGET = 2'd2;

  localparam logic [STAT_W-1:0] ST_PLACED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd2;

  typedef struct packed {
    logic [CW-1:0] top;
    logic [SW-1:0] height;
    logic [SW-1:0] fill;
  } shelf_entry_t;

endpackage

[hw/rtl/shelf_atlas_allocator_unit.sv]
// Shelf-packing rectangle allocator for square atlas pages.
//
// Input channel (in_valid/in_ready): one request per beat. Place requests are
// cut into pieces of at most PAGE_SIZE-2 columns; each piece gives one result
// beat on the output channel (out_valid/out_ready), with out_last on the final
// one. A failed piece gives a single atlas-full beat that ends the request.
// Clear and forget give one done beat; an undefined request gives none.
// cfg_we/cfg_wdata write max_pages; user must do so while idle, unenforced.
//
// Timing: a request is taken only while the unit is idle. Each piece scans
// the shelf table of the current page, one shelf memory read per cycle, and
// moves on to a fresh page when no shelf there fits; a place request repeats
// the scan for each piece. Clear/forget go straight to their done beat.
// The result sits in an output register; a stalled receiver holds the next
// piece in its emit state, the scan state is kept meanwhile.
// Reset: synchronous, clears page/shelf counts and sets max_pages to 1; the
// shelf memory itself is not cleared, only entries below shelf_count are read.
module shelf_atlas_allocator_unit
  import saa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_we,
  input  logic [PAGE_W-1:0]   cfg_wdata,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [IN_WW-1:0]    in_width,
  input  logic [IN_HW-1:0]    in_height,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   out_status,
  output logic [PAGE_W-1:0]   out_page,
  output logic [OUT_CW-1:0]   out_cell_x,
  output logic [OUT_CW-1:0]   out_cell_y,
  output logic [OUT_CW-1:0]   out_cell_w,
  output logic [OUT_CW-1:0]   out_cell_h,
  output logic                out_last
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_OPEN      = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_EMIT_CELL = 3'd3;
  localparam logic [2:0] S_EMIT_STAT = 3'd4;

  // control registers
  logic [2:0]            state_r, state_nxt;
  logic [PAGE_W-1:0]     max_pages_r, max_pages_nxt;
  logic [PAGE_W-1:0]     page_count_r, page_count_nxt;
  logic [SHELF_CNTW-1:0] shelf_count_r, shelf_count_nxt;
  logic [SW-1:0]         top_row_r, top_row_nxt;
  logic                  pass_r, pass_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // request and scan payload
  logic [IN_WW-1:0]      rest_r, rest_nxt;
  logic [IN_HW-1:0]      h_r, h_nxt;
  logic [AH_W-1:0]       ah_r, ah_nxt;
  logic [AHL_W-1:0]      ah_lim_r, ah_lim_nxt;
  logic [SHELF_CNTW-1:0] scan_i_r, scan_i_nxt;
  logic [SHELF_AW-1:0]   chk_idx_r, chk_idx_nxt;
  logic [CW-1:0]         res_x_r, res_x_nxt;
  logic [CW-1:0]         res_y_r, res_y_nxt;
  logic [STAT_W-1:0]     stat_r, stat_nxt;

  // output register payload
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [PAGE_W-1:0]     out_page_r, out_page_nxt;
  logic [OUT_CW-1:0]     out_cell_x_r, out_cell_x_nxt;
  logic [OUT_CW-1:0]     out_cell_y_r, out_cell_y_nxt;
  logic [OUT_CW-1:0]     out_cell_w_r, out_cell_w_nxt;
  logic [OUT_CW-1:0]     out_cell_h_r, out_cell_h_nxt;
  logic                  out_last_r, out_last_nxt;

  // shelf memory with a registered read port
  shelf_entry_t          shelf_mem [MAX_SHELVES];
  shelf_entry_t          rd_data_r;
  logic                  mem_we, mem_re;
  logic [SHELF_AW-1:0]   mem_wa, mem_ra;
  shelf_entry_t          mem_wd;

  // piece geometry
  logic [CW-1:0]         pw;
  logic [SW-1:0]         aw;
  logic                  last_piece;
  logic [PAGE_W-1:0]     page_lim;
  logic                  slot_free;
  logic                  match;
  logic                  more;
  logic                  new_fits;
  logic                  in_acc;

  assign last_piece = (rest_r <= IN_WW'(PIECE_MAX));
  assign pw         = last_piece ? rest_r[CW-1:0] : CW'(PIECE_MAX);
  assign aw         = {1'b0, pw} + SW'(2);
  assign page_lim   = (max_pages_r == '0) ? PAGE_W'(1) : max_pages_r;
  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;

  // shelf qualifies: tall enough, at most 25% too tall, room for the width
  // (fill and width can both be a full page, so the sum needs one more bit)
  assign match = chk_vld_r &&
                 (AH_W'(rd_data_r.height) >= ah_r) &&
                 (AHL_W'(rd_data_r.height) <= ah_lim_r) &&
                 (({1'b0, rd_data_r.fill} + {1'b0, aw}) <= {1'b0, SW'(PAGE_SIZE)});
  assign more     = (scan_i_r < shelf_count_r);
  assign new_fits = (shelf_count_r < SHELF_CNTW'(MAX_SHELVES)) &&
                    ((AHL_W'(top_row_r) + AHL_W'(ah_r)) <= AHL_W'(PAGE_SIZE));

  always_comb begin
    state_nxt       = state_r;
    max_pages_nxt   = cfg_we ? cfg_wdata : max_pages_r;
    page_count_nxt  = page_count_r;
    shelf_count_nxt = shelf_count_r;
    top_row_nxt     = top_row_r;
    pass_nxt        = pass_r;
    chk_vld_nxt     = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;

    rest_nxt        = rest_r;
    h_nxt           = h_r;
    ah_nxt          = ah_r;
    ah_lim_nxt      = ah_lim_r;
    scan_i_nxt      = scan_i_r;
    chk_idx_nxt     = chk_idx_r;
    res_x_nxt       = res_x_r;
    res_y_nxt       = res_y_r;
    stat_nxt        = stat_r;

    out_status_nxt  = out_status_r;
    out_page_nxt    = out_page_r;
    out_cell_x_nxt  = out_cell_x_r;
    out_cell_y_nxt  = out_cell_y_r;
    out_cell_w_nxt  = out_cell_w_r;
    out_cell_h_nxt  = out_cell_h_r;
    out_last_nxt    = out_last_r;

    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = chk_idx_r;
    mem_ra = scan_i_r[SHELF_AW-1:0];
    mem_wd = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            REQ_PLACE: begin
              rest_nxt   = in_width;
              h_nxt      = in_height;
              ah_nxt     = AH_W'(in_height) + AH_W'(2);
              ah_lim_nxt = AHL_W'(AH_W'(in_height) + AH_W'(2)) +
                           AHL_W'((AH_W'(in_height) + AH_W'(2)) >> 2);
              pass_nxt   = 1'b0;
              state_nxt  = S_OPEN;
            end
            REQ_CLEAR: begin
              shelf_count_nxt = '0;
              top_row_nxt     = '0;
              if (page_count_r > PAGE_W'(1)) begin
                page_count_nxt = PAGE_W'(1);
              end
              stat_nxt  = ST_DONE;
              state_nxt = S_EMIT_STAT;
            end
            REQ_FORGET: begin
              shelf_count_nxt = '0;
              top_row_nxt     = '0;
              page_count_nxt  = '0;
              stat_nxt        = ST_DONE;
              state_nxt       = S_EMIT_STAT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_OPEN: begin
        // a fresh page on the second try, or when none is open yet
        scan_i_nxt = '0;
        if (pass_r || (page_count_r == '0)) begin
          if (page_count_r >= page_lim) begin
            stat_nxt  = ST_FULL;
            state_nxt = S_EMIT_STAT;
          end else begin
            page_count_nxt  = page_count_r + PAGE_W'(1);
            shelf_count_nxt = '0;
            top_row_nxt     = '0;
            state_nxt       = S_SCAN;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // rd_data_r holds entry chk_idx_r; reads stop once a shelf qualifies
        if (match) begin
          mem_we      = 1'b1;
          mem_wa      = chk_idx_r;
          mem_wd      = rd_data_r;
          mem_wd.fill = rd_data_r.fill + aw;
          res_x_nxt   = rd_data_r.fill[CW-1:0] + CW'(1);
          res_y_nxt   = rd_data_r.top + CW'(1);
          state_nxt   = S_EMIT_CELL;
        end else if (more) begin
          mem_re      = 1'b1;
          mem_ra      = scan_i_r[SHELF_AW-1:0];
          scan_i_nxt  = scan_i_r + SHELF_CNTW'(1);
          chk_idx_nxt = scan_i_r[SHELF_AW-1:0];
          chk_vld_nxt = 1'b1;
        end else if (new_fits) begin
          mem_we          = 1'b1;
          mem_wa          = shelf_count_r[SHELF_AW-1:0];
          mem_wd.top      = top_row_r[CW-1:0];
          mem_wd.height   = ah_r[SW-1:0];
          mem_wd.fill     = aw;
          top_row_nxt     = top_row_r + ah_r[SW-1:0];
          shelf_count_nxt = shelf_count_r + SHELF_CNTW'(1);
          res_x_nxt       = CW'(1);
          res_y_nxt       = top_row_r[CW-1:0] + CW'(1);
          state_nxt       = S_EMIT_CELL;
        end else if (!pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = S_OPEN;
        end else begin
          stat_nxt  = ST_FULL;
          state_nxt = S_EMIT_STAT;
        end
      end

      S_EMIT_CELL: begin
        // memory write of this piece is done, so the next scan sees it
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_PLACED;
          out_page_nxt   = page_count_r - PAGE_W'(1);
          out_cell_x_nxt = OUT_CW'(res_x_r);
          out_cell_y_nxt = OUT_CW'(res_y_r);
          out_cell_w_nxt = OUT_CW'(pw);
          out_cell_h_nxt = h_r[OUT_CW-1:0];
          out_last_nxt   = last_piece;
          if (last_piece) begin
            state_nxt = S_IDLE;
          end else begin
            rest_nxt  = rest_r - IN_WW'(PIECE_MAX);
            pass_nxt  = 1'b0;
            state_nxt = S_OPEN;
          end
        end
      end

      S_EMIT_STAT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_page_nxt   = '0;
          out_cell_x_nxt = '0;
          out_cell_y_nxt = '0;
          out_cell_w_nxt = '0;
          out_cell_h_nxt = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      max_pages_r   <= PAGE_W'(1);
      page_count_r  <= '0;
      shelf_count_r <= '0;
      top_row_r     <= '0;
      pass_r        <= 1'b0;
      chk_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      max_pages_r   <= max_pages_nxt;
      page_count_r  <= page_count_nxt;
      shelf_count_r <= shelf_count_nxt;
      top_row_r     <= top_row_nxt;
      pass_r        <= pass_nxt;
      chk_vld_r     <= chk_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r       <= rest_nxt;
    h_r          <= h_nxt;
    ah_r         <= ah_nxt;
    ah_lim_r     <= ah_lim_nxt;
    scan_i_r     <= scan_i_nxt;
    chk_idx_r    <= chk_idx_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_cell_x_r <= out_cell_x_nxt;
    out_cell_y_r <= out_cell_y_nxt;
    out_cell_w_r <= out_cell_w_nxt;
    out_cell_h_r <= out_cell_h_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shelf_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= shelf_mem[mem_ra];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_page   = out_page_r;
  assign out_cell_x = out_cell_x_r;
  assign out_cell_y = out_cell_y_r;
  assign out_cell_w = out_cell_w_r;
  assign out_cell_h = out_cell_h_r;
  assign out_last   = out_last_r;

endmodule
